// ----- sv/ssrl_pkg.sv -----
// ----------------------------------------------------------------------------
// ssrl_pkg - shared types and constants for the session start rate limiter
// Sequencer states, field widths, bucket table sizing and helper functions.
// ----------------------------------------------------------------------------
package ssrl_pkg;

    // Field widths
    localparam int TIME_W   = 48;
    localparam int QUOTA_W  = 16;
    localparam int RID_W    = 16;
    localparam int CONC_W   = 5;
    localparam int CFG_W    = 16;

    // Bucket table sizing
    localparam int BUCKET_CAP = 16;
    localparam int BUCKET_W   = $clog2(BUCKET_CAP);
    localparam int ITER_W     = $clog2(RID_W);

    // Spacing between grants on one bucket
    localparam logic [TIME_W-1:0] SPACING_MS = TIME_W'(5000);
    localparam logic [TIME_W-1:0] TIME_MAX   = {TIME_W{1'b1}};

    // Configuration register indexes
    localparam logic CFG_QUOTA_TOTAL = 1'b0;
    localparam logic CFG_MAX_CONC    = 1'b1;

    // Input modes
    localparam logic MODE_REQUEST = 1'b0;
    localparam logic MODE_LOAD    = 1'b1;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_REFILL,
        S_QWAIT,
        S_MOD,
        S_BDIFF,
        S_BCMP,
        S_GRANT,
        S_OUT
    } t_state;

    // Concurrency with zero taken as one and a clamp at the table size
    function automatic logic [CONC_W-1:0] f_conc(input logic [CONC_W-1:0] raw);
        logic [CONC_W-1:0] c;
        c = raw;
        if (c == '0) begin
            c = CONC_W'(1);
        end else if (c > CONC_W'(BUCKET_CAP)) begin
            c = CONC_W'(BUCKET_CAP);
        end
        return c;
    endfunction

endpackage

// ----- sv/session_start_rate_limiter.sv -----
// ----------------------------------------------------------------------------
// session_start_rate_limiter - windowed quota admission with bucket spacing
//
// Usage:
//   Request channel (i_valid/o_ready) carries a mode, the current time and
//   a requester id, or a quota load (count and window reset time). Every
//   request yields exactly one response on (o_valid/i_ready): grant flag,
//   wait in ms, quota left and the bucket used.
//   Sequence: a load answers in the cycle after acceptance. A start request
//   runs refill, quota wait, remainder, bucket wait, compare and grant states
//   around one shared 48-bit add/subtract unit, with the bucket index from a
//   bit-serial remainder unit, then registers the response.
//   Throughput: one request at a time; o_ready is high only while idle, so
//   a new request is taken the cycle after the previous response is taken.
//   A stalled receiver holds the response and the block until i_ready.
//   Reset (synchronous, i_rst_n low) clears the quota, the window reset time
//   and all bucket times, and sets the quota total and the bucket count to 1.
//   Configuration writes (i_cfg_we) take effect at once and are expected
//   only while the block is idle.
// ----------------------------------------------------------------------------
module session_start_rate_limiter
    import ssrl_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    // Configuration
    input  logic                i_cfg_we,
    input  logic                i_cfg_idx,
    input  logic [CFG_W-1:0]    i_cfg_data,
    // Request channel
    input  logic                i_valid,
    output logic                o_ready,
    input  logic                i_mode,
    input  logic [TIME_W-1:0]   i_now_ms,
    input  logic [RID_W-1:0]    i_requester_id,
    input  logic [QUOTA_W-1:0]  i_load_remaining,
    input  logic [TIME_W-1:0]   i_load_reset_at,
    // Response channel
    output logic                o_valid,
    input  logic                i_ready,
    output logic                o_granted,
    output logic [TIME_W-1:0]   o_wait_ms,
    output logic [QUOTA_W-1:0]  o_quota_left,
    output logic [BUCKET_W-1:0] o_bucket_used
);

    t_state r_state, n_state;

    // Configuration registers
    logic [QUOTA_W-1:0] r_quota_total;
    logic [CONC_W-1:0]  r_max_conc;

    // Block state
    logic [QUOTA_W-1:0] r_quota, n_quota;
    logic [TIME_W-1:0]  r_wrt, n_wrt;
    logic [TIME_W-1:0]  r_tbl [BUCKET_CAP];

    // Working registers
    logic [TIME_W-1:0]   r_now, n_now;
    logic [RID_W-1:0]    r_rid, n_rid;
    logic [TIME_W-1:0]   r_wait, n_wait;
    logic [TIME_W-1:0]   r_next, n_next;
    logic [TIME_W-1:0]   r_bdiff, n_bdiff;
    logic [BUCKET_W-1:0] r_bucket, n_bucket;

    // Response registers
    logic                r_granted, n_granted;
    logic [TIME_W-1:0]   r_owait, n_owait;
    logic [QUOTA_W-1:0]  r_oquota, n_oquota;
    logic [BUCKET_W-1:0] r_obucket, n_obucket;

    // Table write
    logic                s_tbl_we;
    logic [TIME_W-1:0]   s_tbl_wdata;

    // Shared add/subtract unit
    logic                s_sub;
    logic [TIME_W-1:0]   s_a, s_b;
    logic [TIME_W:0]     s_sum;
    logic [TIME_W-1:0]   s_diff;
    logic                s_ge;

    // Remainder unit
    logic                s_mod_start;
    logic                s_mod_busy;
    logic [BUCKET_W-1:0] s_mod_rem;

    logic                s_accept;

    assign s_accept = i_valid && (r_state == S_IDLE);

    // Shared unit: a + b, or a - b with carry out meaning a >= b
    always_comb begin
        s_sum  = {1'b0, s_a} + {1'b0, (s_sub ? ~s_b : s_b)} + (TIME_W+1)'(s_sub);
        s_diff = s_sum[TIME_W-1:0];
        s_ge   = s_sum[TIME_W];
    end

    ssrl_mod_unit u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (s_mod_start),
        .i_dividend (r_rid),
        .i_divisor  (f_conc(r_max_conc)),
        .o_busy     (s_mod_busy),
        .o_rem      (s_mod_rem)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = (i_mode == MODE_LOAD) ? S_OUT : S_REFILL;
                end
            end
            S_REFILL: n_state = S_QWAIT;
            S_QWAIT:  n_state = S_MOD;
            S_MOD: begin
                if (!s_mod_busy) begin
                    n_state = S_BDIFF;
                end
            end
            S_BDIFF:  n_state = S_BCMP;
            S_BCMP:   n_state = S_GRANT;
            S_GRANT:  n_state = S_OUT;
            S_OUT: begin
                if (i_ready) begin
                    n_state = S_IDLE;
                end
            end
            default:  n_state = S_IDLE;
        endcase
    end

    // Datapath and unit control per state
    always_comb begin
        n_quota     = r_quota;
        n_wrt       = r_wrt;
        n_now       = r_now;
        n_rid       = r_rid;
        n_wait      = r_wait;
        n_next      = r_next;
        n_bdiff     = r_bdiff;
        n_bucket    = r_bucket;
        n_granted   = r_granted;
        n_owait     = r_owait;
        n_oquota    = r_oquota;
        n_obucket   = r_obucket;
        s_tbl_we    = 1'b0;
        s_tbl_wdata = r_now;
        s_sub       = 1'b1;
        s_a         = r_now;
        s_b         = r_wrt;
        s_mod_start = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (s_accept) begin
                    n_now = i_now_ms;
                    n_rid = i_requester_id;
                    if (i_mode == MODE_LOAD) begin
                        n_quota   = i_load_remaining;
                        n_wrt     = i_load_reset_at;
                        n_granted = 1'b0;
                        n_owait   = '0;
                        n_oquota  = i_load_remaining;
                        n_obucket = '0;
                    end
                end
            end
            S_REFILL: begin
                // now >= a nonzero reset time refills an empty quota
                s_mod_start = 1'b1;
                s_a = r_now;
                s_b = r_wrt;
                if (r_quota == '0 && r_wrt != '0 && s_ge) begin
                    n_quota = (r_quota_total != '0) ? r_quota_total : QUOTA_W'(1);
                    n_wrt   = '0;
                end
            end
            S_QWAIT: begin
                // Time left to the window reset while the quota is empty
                s_a = r_wrt;
                s_b = r_now;
                n_wait = (r_quota == '0 && s_ge) ? s_diff : '0;
            end
            S_MOD: begin
                n_bucket = s_mod_rem;
                n_next   = r_tbl[s_mod_rem];
            end
            S_BDIFF: begin
                // Time left on the bucket, zero if already past
                s_a = r_next;
                s_b = r_now;
                n_bdiff = s_ge ? s_diff : '0;
            end
            S_BCMP: begin
                // Keep the larger wait
                s_a = r_wait;
                s_b = r_bdiff;
                if (!s_ge) begin
                    n_wait = r_bdiff;
                end
            end
            S_GRANT: begin
                // On a grant, arm bucket now + spacing, saturating at end of time
                s_sub = 1'b0;
                s_a   = r_now;
                s_b   = SPACING_MS;
                n_granted = (r_wait == '0);
                if (r_wait == '0) begin
                    s_tbl_we    = 1'b1;
                    s_tbl_wdata = s_sum[TIME_W] ? TIME_MAX : s_diff;
                    if (r_quota != '0) begin
                        n_quota = r_quota - QUOTA_W'(1);
                    end
                end
                n_owait   = r_wait;
                n_oquota  = n_quota;
                n_obucket = r_bucket;
            end
            S_OUT: begin
            end
            default: begin
            end
        endcase
    end

    // Control state and block state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_quota_total <= QUOTA_W'(1);
            r_max_conc    <= CONC_W'(1);
            r_quota       <= '0;
            r_wrt         <= '0;
            for (int i = 0; i < BUCKET_CAP; i++) begin
                r_tbl[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_quota <= n_quota;
            r_wrt   <= n_wrt;
            if (s_tbl_we) begin
                r_tbl[r_bucket] <= s_tbl_wdata;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_QUOTA_TOTAL: r_quota_total <= i_cfg_data[QUOTA_W-1:0];
                    CFG_MAX_CONC:    r_max_conc    <= i_cfg_data[CONC_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // Working and response registers
    always_ff @(posedge i_clk) begin
        r_now     <= n_now;
        r_rid     <= n_rid;
        r_wait    <= n_wait;
        r_next    <= n_next;
        r_bdiff   <= n_bdiff;
        r_bucket  <= n_bucket;
        r_granted <= n_granted;
        r_owait   <= n_owait;
        r_oquota  <= n_oquota;
        r_obucket <= n_obucket;
    end

    assign o_ready       = (r_state == S_IDLE);
    assign o_valid       = (r_state == S_OUT);
    assign o_granted     = r_granted;
    assign o_wait_ms     = r_owait;
    assign o_quota_left  = r_oquota;
    assign o_bucket_used = r_obucket;

endmodule

// ----- sv/ssrl_mod_unit.sv -----
// ----------------------------------------------------------------------------
// ssrl_mod_unit - bit-serial remainder unit
// Restoring remainder of a 16-bit id by a divisor of 1..BUCKET_CAP,
// one dividend bit per cycle.
// ----------------------------------------------------------------------------
module ssrl_mod_unit
    import ssrl_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [RID_W-1:0]    i_dividend,
    input  logic [CONC_W-1:0]   i_divisor,
    output logic                o_busy,
    output logic [BUCKET_W-1:0] o_rem
);

    logic                r_busy;
    logic [ITER_W-1:0]   r_cnt;
    logic [BUCKET_W-1:0] r_rem;
    logic [RID_W-1:0]    r_shift;
    logic [CONC_W-1:0]   r_div;

    logic [BUCKET_W:0]   s_trial;
    logic [BUCKET_W:0]   s_sub;
    logic [BUCKET_W-1:0] n_rem;

    // One restoring step: shift in next dividend bit, subtract if it fits
    always_comb begin
        s_trial = {r_rem, r_shift[RID_W-1]};
        s_sub   = s_trial - (BUCKET_W+1)'(r_div);
        if (s_trial >= (BUCKET_W+1)'(r_div)) begin
            n_rem = s_sub[BUCKET_W-1:0];
        end else begin
            n_rem = s_trial[BUCKET_W-1:0];
        end
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + ITER_W'(1);
            if (r_cnt == ITER_W'(RID_W - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem   <= '0;
            r_shift <= i_dividend;
            r_div   <= i_divisor;
        end else if (r_busy) begin
            r_rem   <= n_rem;
            r_shift <= {r_shift[RID_W-2:0], 1'b0};
        end
    end

    assign o_busy = r_busy;
    assign o_rem  = r_rem;

endmodule

// ----- tb/sv/tb_session_start_rate_limiter.sv -----
// ----------------------------------------------------------------------------
// tb_session_start_rate_limiter - admission checks for the start rate limiter
// Drives start requests and quota loads over the request channel, predicts
// each response from a behavioral copy of the quota, window and bucket state,
// and compares every response field against the oldest pending prediction.
// ----------------------------------------------------------------------------
module tb_session_start_rate_limiter
    import ssrl_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_PCT  = 22;
    localparam int WDOG_LIMIT = 5000;
    localparam int ROUNDS     = 8;
    localparam int ROUND_LEN  = 106;

    // Predicted response of one request
    typedef struct packed {
        logic                granted;
        logic [TIME_W-1:0]   wait_ms;
        logic [QUOTA_W-1:0]  quota_left;
        logic [BUCKET_W-1:0] bucket;
    } admit_result_t;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_cfg_we = 1'b0;
    logic                i_cfg_idx = 1'b0;
    logic [CFG_W-1:0]    i_cfg_data = '0;
    logic                i_valid = 1'b0;
    logic                o_ready;
    logic                i_mode = 1'b0;
    logic [TIME_W-1:0]   i_now_ms = '0;
    logic [RID_W-1:0]    i_requester_id = '0;
    logic [QUOTA_W-1:0]  i_load_remaining = '0;
    logic [TIME_W-1:0]   i_load_reset_at = '0;
    logic                o_valid;
    logic                i_ready = 1'b0;
    logic                o_granted;
    logic [TIME_W-1:0]   o_wait_ms;
    logic [QUOTA_W-1:0]  o_quota_left;
    logic [BUCKET_W-1:0] o_bucket_used;

    // Predictor state and configuration
    logic [QUOTA_W-1:0]  quota_cnt;
    logic [TIME_W-1:0]   window_reset_ms;
    logic [TIME_W-1:0]   bucket_free_at [BUCKET_CAP];
    logic [QUOTA_W-1:0]  cfg_quota_total;
    logic [CONC_W-1:0]   cfg_concurrency;

    admit_result_t       admit_expected [$];
    int                  err_cnt = 0;
    int                  quiet_cycles = 0;
    bit                  idle_en = 1'b1;
    logic [TIME_W-1:0]   time_cursor;

    session_start_rate_limiter uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_mode           (i_mode),
        .i_now_ms         (i_now_ms),
        .i_requester_id   (i_requester_id),
        .i_load_remaining (i_load_remaining),
        .i_load_reset_at  (i_load_reset_at),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_granted        (o_granted),
        .o_wait_ms        (o_wait_ms),
        .o_quota_left     (o_quota_left),
        .o_bucket_used    (o_bucket_used)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic logic [TIME_W-1:0] rand_time();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[TIME_W-1:0];
    endfunction

    // Behavioral admission decision; updates the predictor state
    function automatic admit_result_t predict_admission(
        input logic               mode,
        input logic [TIME_W-1:0]  now,
        input logic [RID_W-1:0]   rid,
        input logic [QUOTA_W-1:0] load_rem,
        input logic [TIME_W-1:0]  load_at
    );
        admit_result_t     r;
        int unsigned       conc;
        int unsigned       b;
        logic [TIME_W-1:0] wait_t;
        logic [TIME_W-1:0] slot;
        logic [TIME_W:0]   armed;
        r = '0;
        if (mode == MODE_LOAD) begin
            quota_cnt       = load_rem;
            window_reset_ms = load_at;
        end else begin
            // refill only an exhausted quota whose window has expired
            if (quota_cnt == '0 && window_reset_ms != '0 && now >= window_reset_ms) begin
                quota_cnt       = (cfg_quota_total != '0) ? cfg_quota_total : QUOTA_W'(1);
                window_reset_ms = '0;
            end
            wait_t = '0;
            if (quota_cnt == '0 && window_reset_ms > now) begin
                wait_t = window_reset_ms - now;
            end
            conc = (cfg_concurrency == '0) ? 1 : cfg_concurrency;
            if (conc > BUCKET_CAP) begin
                conc = BUCKET_CAP;
            end
            b    = rid % conc;
            slot = bucket_free_at[b];
            if (slot > now && (slot - now) > wait_t) begin
                wait_t = slot - now;
            end
            if (wait_t == '0) begin
                r.granted = 1'b1;
                armed = {1'b0, now} + SPACING_MS;
                bucket_free_at[b] = (armed > TIME_MAX) ? TIME_MAX : armed[TIME_W-1:0];
                if (quota_cnt != '0) begin
                    quota_cnt = quota_cnt - 1'b1;
                end
            end
            r.wait_ms = wait_t;
            r.bucket  = b[BUCKET_W-1:0];
        end
        r.quota_left = quota_cnt;
        return r;
    endfunction

    // Drive one request and hold it until accepted; starts and ends at a falling edge
    task automatic send_item(
        input logic               mode,
        input logic [TIME_W-1:0]  now,
        input logic [RID_W-1:0]   rid,
        input logic [QUOTA_W-1:0] load_rem,
        input logic [TIME_W-1:0]  load_at
    );
        while (idle_en && $urandom_range(0, 99) < STALL_PCT) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_mode           = mode;
        i_now_ms         = now;
        i_requester_id   = rid;
        i_load_remaining = load_rem;
        i_load_reset_at  = load_at;
        i_valid          = 1'b1;
        @(posedge i_clk);
        while (!o_ready) begin
            @(posedge i_clk);
        end
        admit_expected.push_back(predict_admission(mode, now, rid, load_rem, load_at));
        @(negedge i_clk);
        i_valid = 1'b0;
    endtask

    task automatic send_start(input logic [TIME_W-1:0] now, input logic [RID_W-1:0] rid);
        send_item(MODE_REQUEST, now, rid, QUOTA_W'($urandom), rand_time());
    endtask

    task automatic send_load(input logic [QUOTA_W-1:0] rem, input logic [TIME_W-1:0] at);
        send_item(MODE_LOAD, rand_time(), RID_W'($urandom), rem, at);
    endtask

    // Hold off new requests until every pending response has been taken
    task automatic drain_responses();
        while (admit_expected.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_cfg(input logic idx, input logic [CFG_W-1:0] data);
        drain_responses();
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = data;
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
        if (idx == CFG_QUOTA_TOTAL) begin
            cfg_quota_total = data;
        end else begin
            cfg_concurrency = data[CONC_W-1:0];
        end
    endtask

    // Empty quota with no window pending: grants never wrap the count
    task automatic test_empty_quota();
        send_start('0, '0);
        send_start(TIME_W'(4999), '1);
        send_start(TIME_W'(5000), RID_W'(1));
    endtask

    // Loads set count and window directly, no refill and no bucket change
    task automatic test_quota_load();
        send_load('1, TIME_MAX);
        send_load('0, '0);
        send_load(QUOTA_W'(3), '0);
    endtask

    // Window expiry refills the quota; a zero total refills to one
    task automatic test_window_refill();
        write_cfg(CFG_QUOTA_TOTAL, '0);
        send_load('0, TIME_W'(200000));
        send_start(TIME_W'(150000), RID_W'(2));
        send_start(TIME_W'(200000), RID_W'(2));
        write_cfg(CFG_QUOTA_TOTAL, '1);
        send_load('0, TIME_W'(300000));
        send_start(TIME_W'(300000), RID_W'(3));
    endtask

    // Bucket selection across concurrency settings, including clamp and zero
    task automatic test_bucket_mapping();
        logic [CONC_W-1:0] conc_set [4];
        conc_set = '{CONC_W'(16), CONC_W'(17), '1, '0};
        foreach (conc_set[k]) begin
            write_cfg(CFG_MAX_CONC, {11'h7ff, conc_set[k]});
            send_start(TIME_W'(400000 + k * 20000), '1);
            send_start(TIME_W'(400000 + k * 20000), RID_W'(15 + k));
        end
    endtask

    // Long mixed traffic with an advancing clock and changing configuration
    task automatic test_random_traffic();
        int unsigned sel;
        logic [TIME_W-1:0] at;
        time_cursor = TIME_W'(1_000_000) + (rand_time() >> 8);
        for (int rnd = 0; rnd < ROUNDS; rnd++) begin
            case (rnd)
                0: write_cfg(CFG_QUOTA_TOTAL, CFG_W'(1));
                1: write_cfg(CFG_QUOTA_TOTAL, '0);
                2: write_cfg(CFG_QUOTA_TOTAL, '1);
                default: write_cfg(CFG_QUOTA_TOTAL, ($urandom_range(0, 3) == 0) ?
                                   CFG_W'($urandom) : CFG_W'($urandom_range(1, 6)));
            endcase
            write_cfg(CFG_MAX_CONC, {CFG_W'($urandom_range(0, 2047)) << CONC_W}
                      | CFG_W'((rnd == 1) ? 16 : $urandom_range(0, 31)));
            // one round runs back to back on both sides
            idle_en = (rnd != 3);
            for (int n = 0; n < ROUND_LEN; n++) begin
                if (rnd == 5 && n == ROUND_LEN / 2) begin
                    drain_responses();
                end
                sel = $urandom_range(0, 99);
                time_cursor = time_cursor + TIME_W'($urandom_range(0, 2500));
                if (sel < 10) begin
                    sel = $urandom_range(0, 9);
                    if (sel < 3) begin
                        at = '0;
                    end else if (sel < 9) begin
                        at = time_cursor + TIME_W'($urandom_range(0, 20000));
                    end else begin
                        at = rand_time();
                    end
                    send_load(($urandom_range(0, 4) == 0) ? QUOTA_W'($urandom)
                              : QUOTA_W'($urandom_range(0, 4)), at);
                end else if (sel < 15) begin
                    // stale timestamp at or behind the clock
                    send_start(time_cursor - TIME_W'($urandom_range(0, 20000)),
                               RID_W'($urandom));
                end else begin
                    send_start(time_cursor, RID_W'($urandom));
                end
            end
        end
        idle_en = 1'b1;
    endtask

    // Arming near the end of time saturates; full-range times and windows
    task automatic test_end_of_time();
        logic [RID_W-1:0] rid;
        rid = RID_W'($urandom);
        send_start(TIME_MAX - TIME_W'(100), rid);
        send_start(TIME_MAX, rid);
        send_load(QUOTA_W'($urandom), rand_time());
        repeat (3) send_start(rand_time(), RID_W'($urandom));
    endtask

    // Response side: random back-pressure
    always @(negedge i_clk) begin
        i_ready <= !idle_en || ($urandom_range(0, 99) >= STALL_PCT);
    end

    // Response checker
    always @(posedge i_clk) begin
        admit_result_t exp_r;
        if (i_rst_n && o_valid && i_ready) begin
            if (admit_expected.size() == 0) begin
                $display("%0t unexpected response: granted %0d wait %0h quota %0h bucket %0h",
                         $time, o_granted, o_wait_ms, o_quota_left, o_bucket_used);
                err_cnt++;
            end else begin
                exp_r = admit_expected.pop_front();
                if (o_granted !== exp_r.granted) begin
                    $display("%0t granted mismatch: expected %0h actual %0h",
                             $time, exp_r.granted, o_granted);
                    err_cnt++;
                end
                if (o_wait_ms !== exp_r.wait_ms) begin
                    $display("%0t wait_ms mismatch: expected %0h actual %0h",
                             $time, exp_r.wait_ms, o_wait_ms);
                    err_cnt++;
                end
                if (o_quota_left !== exp_r.quota_left) begin
                    $display("%0t quota_left mismatch: expected %0h actual %0h",
                             $time, exp_r.quota_left, o_quota_left);
                    err_cnt++;
                end
                if (o_bucket_used !== exp_r.bucket) begin
                    $display("%0t bucket_used mismatch: expected %0h actual %0h",
                             $time, exp_r.bucket, o_bucket_used);
                    err_cnt++;
                end
            end
        end
    end

    // Watchdog on cycles with no handshake on either channel
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WDOG_LIMIT) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    initial begin
        quota_cnt       = '0;
        window_reset_ms = '0;
        cfg_quota_total = QUOTA_W'(1);
        cfg_concurrency = CONC_W'(1);
        foreach (bucket_free_at[k]) begin
            bucket_free_at[k] = '0;
        end
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_empty_quota();
        test_quota_load();
        test_window_refill();
        test_bucket_mapping();
        test_random_traffic();
        test_end_of_time();

        // let the last responses drain, then a short settle
        while (admit_expected.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (30) @(posedge i_clk);
        if (err_cnt == 0 && admit_expected.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ----- files.f -----
sv/ssrl_pkg.sv
sv/ssrl_mod_unit.sv
sv/session_start_rate_limiter.sv
tb/sv/tb_session_start_rate_limiter.sv
